@@ rtl/rational_arith_unit_defines.svh @@
// ----------------------------------------------------------------------------
// rational_arith_unit_defines
// Assertion helpers of the rational arithmetic unit sequencer.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_arith_unit check failed");

// Next-cycle implication, disabled while reset is low.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_arith_unit check failed");

`endif

@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and control structs of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_DIV    = 3'd3;
    localparam logic [2:0] OP_CMP    = 3'd4;
    localparam logic [2:0] OP_REDUCE = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam logic [1:0] MSTEP_0 = 2'd0;
    localparam logic [1:0] MSTEP_1 = 2'd1;
    localparam logic [1:0] MSTEP_2 = 2'd2;

    localparam logic signed [63:0] INT64_MAX = 64'sh7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       form;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic early_exit;
        logic is_cmp;
        logic gcd_done;
        logic div_done;
    } t_sts;

endpackage

@@ rtl/rational_arith_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply, divide, compare and reduce on two fractions.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) takes an opcode and two
// fractions; the output channel (o_out_valid / i_out_ready / o_out_data)
// returns one result per item: reduced numerator, positive denominator,
// compare order and status. One item is worked at a time.
// From input transfer to output valid the sequencer runs the multiply steps
// on the shared multiplier, a form step, the binary gcd loop (one subtract or
// shift per cycle), a divider setup step and the bit-serial restoring
// division, then loads the output register. Errors and invalid opcodes go
// from the multiply state straight to the output load; compare skips the gcd
// loop and the division after the form step. The next input can be taken in
// the cycle after the result is loaded.
// o_in_ready is high only while the sequencer is idle; a new item may be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register frees up. Reset empties the output and idles the block.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rau_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rau_pkg::t_out o_out_data
);
    import rau_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

@@ rtl/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, shared multiplier, binary gcd and twin restoring divider.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         i_clk,
    input  rau_pkg::t_in i_in_data,
    input  rau_pkg::t_cmd i_cmd,
    output rau_pkg::t_sts o_sts,
    output rau_pkg::t_out o_out_data
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int SW = MW + 2;
    localparam int KW = $clog2(MW);
    localparam int CW = $clog2(MW + 1);

    logic [2:0]    r_op;
    logic          r_an_neg, r_ad_neg, r_bn_neg, r_bd_neg;
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic [MW-1:0] r_p1, r_p2, r_p3;
    logic          r_nneg, r_dneg;
    logic [1:0]    r_order;
    logic [MW-1:0] r_nm, r_dm;
    logic [MW-1:0] r_gx, r_gy;
    logic [KW-1:0] r_gk;
    logic [MW-1:0] r_g;
    logic [MW-1:0] r_qn, r_rn, r_qd, r_rd;
    logic [CW-1:0] r_cnt;
    t_out          r_out;

    logic [W-1:0]  v_an, v_ad, v_bn, v_bd;
    logic [W-1:0]  mx, my;
    logic [1:0]    st;
    logic          early;
    logic signed [SW-1:0] lval, rval, sum;
    logic [MW-1:0] n_nm, n_dm;
    logic          n_nneg, n_dneg;
    logic [1:0]    n_order;
    logic [MW:0]   tn, td;
    logic [MW-1:0] gval;
    logic [63:0]   num64;
    logic          res_neg;
    t_out          n_out;

    assign v_an = i_in_data.a_num[W-1:0];
    assign v_ad = i_in_data.a_den[W-1:0];
    assign v_bn = i_in_data.b_num[W-1:0];
    assign v_bd = i_in_data.b_den[W-1:0];

    // Sign-magnitude capture at the input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_data.opcode;
            r_an_neg <= v_an[W-1];
            r_ad_neg <= v_ad[W-1];
            r_bn_neg <= v_bn[W-1];
            r_bd_neg <= v_bd[W-1];
            r_an     <= v_an[W-1] ? W'(0) - v_an : v_an;
            r_ad     <= v_ad[W-1] ? W'(0) - v_ad : v_ad;
            r_bn     <= v_bn[W-1] ? W'(0) - v_bn : v_bn;
            r_bd     <= v_bd[W-1] ? W'(0) - v_bd : v_bd;
        end
    end

    always_comb begin
        st = ST_OK;
        if (r_ad == '0 || (r_op != OP_REDUCE && r_bd == '0)) begin
            st = ST_ZERO_DEN;
        end else if (r_op == OP_DIV && r_bn == '0) begin
            st = ST_DIV_ZERO;
        end
        early = (r_op > OP_REDUCE) || (st != ST_OK);
    end

    // One multiplier, operands picked per step
    always_comb begin
        mx = r_an;
        my = r_bd;
        case (i_cmd.mul_step)
            MSTEP_0: begin
                mx = r_an;
                my = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            MSTEP_1: begin
                mx = r_ad;
                my = (r_op == OP_MUL) ? r_bd : r_bn;
            end
            default: begin
                mx = r_ad;
                my = r_bd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_step)
                MSTEP_0: r_p1 <= MW'(mx) * MW'(my);
                MSTEP_1: r_p2 <= MW'(mx) * MW'(my);
                default: r_p3 <= MW'(mx) * MW'(my);
            endcase
        end
    end

    // Build numerator and denominator of the unreduced result
    always_comb begin
        lval = (r_an_neg ^ r_bd_neg) ? SW'(0) - SW'(r_p1) : SW'(r_p1);
        rval = (r_bn_neg ^ r_ad_neg) ? SW'(0) - SW'(r_p2) : SW'(r_p2);
        sum  = (r_op == OP_SUB) ? lval - rval : lval + rval;
        n_nm   = r_p1;
        n_nneg = r_an_neg ^ r_bd_neg;
        n_dm   = r_p2;
        n_dneg = r_ad_neg ^ r_bd_neg;
        case (r_op)
            OP_ADD, OP_SUB: begin
                n_nneg = sum[SW-1];
                n_nm   = sum[SW-1] ? MW'(SW'(0) - sum) : MW'(sum);
                n_dm   = r_p3;
                n_dneg = r_ad_neg ^ r_bd_neg;
            end
            OP_MUL: begin
                n_nneg = r_an_neg ^ r_bn_neg;
            end
            OP_DIV: begin
                n_dneg = r_ad_neg ^ r_bn_neg;
            end
            default: begin
                n_nm   = MW'(r_an);
                n_nneg = r_an_neg;
                n_dm   = MW'(r_ad);
                n_dneg = r_ad_neg;
            end
        endcase
        // compare: sign of (a_num*sgn(a_den)*|b_den| - b_num*sgn(b_den)*|a_den|)
        lval = (r_an_neg ^ r_ad_neg) ? SW'(0) - SW'(r_p1) : SW'(r_p1);
        rval = (r_bn_neg ^ r_bd_neg) ? SW'(0) - SW'(r_p2) : SW'(r_p2);
        if (lval < rval) begin
            n_order = ORD_LESS;
        end else if (lval == rval) begin
            n_order = ORD_EQUAL;
        end else begin
            n_order = ORD_GREATER;
        end
    end

    assign gval = (r_gx | r_gy) << r_gk;

    always_ff @(posedge i_clk) begin
        if (i_cmd.form) begin
            r_nm    <= n_nm;
            r_dm    <= n_dm;
            r_nneg  <= n_nneg;
            r_dneg  <= n_dneg;
            r_order <= n_order;
            r_gx    <= n_nm;
            r_gy    <= n_dm;
            r_gk    <= '0;
        end else if (i_cmd.gcd_step && !o_sts.gcd_done) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_gk <= r_gk + KW'(1);
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                r_gx <= r_gx - r_gy;
            end else begin
                r_gy <= r_gy - r_gx;
            end
        end
    end

    assign tn = {r_rn, r_qn[MW-1]};
    assign td = {r_rd, r_qd[MW-1]};

    // Restoring division of both terms by the gcd, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_g   <= gval;
            r_qn  <= r_nm;
            r_qd  <= r_dm;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= CW'(MW);
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
            if (tn >= {1'b0, r_g}) begin
                r_rn <= MW'(tn - {1'b0, r_g});
                r_qn <= {r_qn[MW-2:0], 1'b1};
            end else begin
                r_rn <= tn[MW-1:0];
                r_qn <= {r_qn[MW-2:0], 1'b0};
            end
            if (td >= {1'b0, r_g}) begin
                r_rd <= MW'(td - {1'b0, r_g});
                r_qd <= {r_qd[MW-2:0], 1'b1};
            end else begin
                r_rd <= td[MW-1:0];
                r_qd <= {r_qd[MW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        num64   = 64'(r_qn);
        res_neg = (r_qn != '0) && (r_nneg ^ r_dneg);
        n_out   = '0;
        if (early) begin
            n_out.status = (r_op > OP_REDUCE) ? ST_OK : st;
        end else if (r_op == OP_CMP) begin
            n_out.order = r_order;
        end else begin
            if (res_neg) begin
                n_out.res_num = 64'(0) - num64;
            end else if (num64[63]) begin
                n_out.res_num = INT64_MAX;
            end else begin
                n_out.res_num = num64;
            end
            n_out.res_den = 63'(r_qd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_sts.early_exit = early;
    assign o_sts.is_cmp     = (r_op == OP_CMP);
    assign o_sts.gcd_done   = (r_gx == '0) || (r_gy == '0);
    assign o_sts.div_done   = (r_cnt == '0);
    assign o_out_data       = r_out;

endmodule

@@ rtl/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply steps, gcd, division, and the output register valid.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_defines.svh"

module rau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd o_cmd
);
    import rau_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_FORM  = 7'b0000100,
        S_GCD   = 7'b0001000,
        S_DINIT = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_step = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                n_step     = MSTEP_0;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (i_sts.early_exit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.mul_en = 1'b1;
                    n_step       = r_step + 2'd1;
                    if (r_step == MSTEP_2) begin
                        n_state = S_FORM;
                    end
                end
            end
            S_FORM: begin
                o_cmd.form = 1'b1;
                n_state    = i_sts.is_cmp ? S_DONE : S_GCD;
            end
            S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_sts.gcd_done) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= MSTEP_0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `RAU_ASSERT_IMP(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load, out_free)
    `RAU_ASSERT_NXT(a_accept_to_mul, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_MUL)
    `RAU_ASSERT_NXT(a_done_sets_valid, i_clk, i_rst_n, r_state == S_DONE && out_free, r_out_valid)
    `RAU_ASSERT_IMP(a_div_init_after_gcd, i_clk, i_rst_n, o_cmd.div_init, i_sts.gcd_done)

endmodule
